/* sv/dmh_pkg.sv */
// ----------------------------------------------------------------------------
// dmh_pkg
// Shared types and constants of the deadline min-heap timer queue: command
// and result words, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package dmh_pkg;

  // Default configuration
  localparam int unsigned HEAP_DEPTH_DEF = 32;
  localparam int unsigned TIME_BITS_DEF  = 48;

  // Fixed field widths
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned DELAY_W  = 32;
  localparam int unsigned PEND_W   = 6;

  typedef enum logic {
    MODE_SCHED = 1'b0,
    MODE_TICK  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    KIND_QUEUED   = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_REJECT   = 2'd2,
    KIND_EXPIRE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_RW,
    ST_CHECK,
    ST_POP_LAST,
    ST_DN_L,
    ST_DN_LW,
    ST_DN_RW
  } state_e;

  // Command word
  typedef struct packed {
    mode_e               mode;
    logic [HANDLE_W-1:0] job_handle;
    logic [DELAY_W-1:0]  delay;
  } dmh_req_t;

  // Result word
  typedef struct packed {
    kind_e               kind;
    logic [HANDLE_W-1:0] job_handle_out;
    logic [PEND_W-1:0]   pending;
    logic                last;
  } dmh_res_t;

  // Result word with its strobe, from the sequencer to the output register
  typedef struct packed {
    logic     valid;
    dmh_res_t res;
  } dmh_emit_t;

endpackage

/* sv/dmh_ram.sv */
// ----------------------------------------------------------------------------
// dmh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmh_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/dmh_ctrl.sv */
// ----------------------------------------------------------------------------
// dmh_ctrl
// Heap sequencer: millisecond counter, heap count, root copy and the sift-up /
// sift-down walk, all driven through one shared deadline comparator.
// ----------------------------------------------------------------------------
module dmh_ctrl #(
  parameter int unsigned HEAP_DEPTH = dmh_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned TIME_BITS  = dmh_pkg::TIME_BITS_DEF,
  localparam int unsigned IDX_W     = $clog2(HEAP_DEPTH),
  localparam int unsigned ENT_W     = TIME_BITS + dmh_pkg::HANDLE_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dmh_pkg::dmh_req_t   req_i,
  output dmh_pkg::dmh_emit_t  emit_o,
  output logic                ram_we_o,
  output logic [IDX_W-1:0]    ram_waddr_o,
  output logic [ENT_W-1:0]    ram_wdata_o,
  output logic [IDX_W-1:0]    ram_raddr_o,
  input  logic [ENT_W-1:0]    ram_rdata_i
);

  localparam int unsigned CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CW    = IDX_W + 2;
  localparam int unsigned HW    = dmh_pkg::HANDLE_W;

  dmh_pkg::state_e   state_q, state_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [ENT_W-1:0]  x_q, x_d;
  logic [ENT_W-1:0]  best_q, best_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic              best_sel_q, best_sel_d;
  logic [TIME_BITS-1:0] root_dl_q, root_dl_d;
  logic [HW-1:0]     root_h_q, root_h_d;
  logic              have_q, have_d;
  logic [HW-1:0]     pop_h_q, pop_h_d;

  logic [TIME_BITS-1:0] cmp_a, cmp_b;
  logic              cmp_lt;
  logic [CW-1:0]     l_w, r_w, cnt_w;
  logic [IDX_W-1:0]  par;
  logic              due;

  // Child and parent positions of the hole
  assign l_w   = CW'({idx_q, 1'b1});
  assign r_w   = l_w + CW'(1);
  assign cnt_w = CW'(cnt_q);
  assign par   = IDX_W'((idx_q - IDX_W'(1)) >> 1);

  // Shared deadline comparator
  assign cmp_lt = cmp_a < cmp_b;
  assign due    = (cnt_q != '0) && !cmp_lt;

  // Hold control and heap walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmh_pkg::ST_IDLE;
      now_q   <= '0;
      cnt_q   <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      cnt_q   <= cnt_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    x_q        <= x_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    best_sel_q <= best_sel_d;
    root_dl_q  <= root_dl_d;
    root_h_q   <= root_h_d;
    pop_h_q    <= pop_h_d;
  end

  // Sequence schedule, tick, push and pop
  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    x_d        = x_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    best_sel_d = best_sel_q;
    have_d     = have_q;
    pop_h_d    = pop_h_q;
    root_dl_d  = root_dl_q;
    root_h_d   = root_h_q;
    busy       = 1'b1;
    emit_o     = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = x_q;
    ram_raddr_o = '0;
    cmp_a      = x_q[ENT_W-1 -: TIME_BITS];
    cmp_b      = ram_rdata_i[ENT_W-1 -: TIME_BITS];

    case (state_q)
      dmh_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (req_i.mode == dmh_pkg::MODE_SCHED) begin
            emit_o.valid              = 1'b1;
            emit_o.res.job_handle_out = req_i.job_handle;
            emit_o.res.last           = 1'b1;
            emit_o.res.pending        = dmh_pkg::PEND_W'(cnt_q);
            if (req_i.delay == '0) begin
              emit_o.res.kind = dmh_pkg::KIND_DISPATCH;
            end else if (cnt_q >= CNT_W'(HEAP_DEPTH)) begin
              emit_o.res.kind = dmh_pkg::KIND_REJECT;
            end else begin
              emit_o.res.kind    = dmh_pkg::KIND_QUEUED;
              emit_o.res.pending = dmh_pkg::PEND_W'(cnt_q + CNT_W'(1));
              cnt_d   = cnt_q + CNT_W'(1);
              x_d     = {now_q + TIME_BITS'(req_i.delay), req_i.job_handle};
              idx_d   = IDX_W'(cnt_q);
              state_d = dmh_pkg::ST_UP_RD;
            end
          end else begin
            now_d   = now_q + TIME_BITS'(1);
            state_d = dmh_pkg::ST_CHECK;
          end
        end
      end

      // Sift up: fetch the parent, or drop the new job at the root
      dmh_pkg::ST_UP_RD: begin
        if (idx_q == '0) begin
          ram_we_o = 1'b1;
          state_d  = dmh_pkg::ST_IDLE;
        end else begin
          ram_raddr_o = par;
          state_d     = dmh_pkg::ST_UP_RW;
        end
      end

      // Move the parent down while it is later than the new job
      dmh_pkg::ST_UP_RW: begin
        ram_we_o = 1'b1;
        if (cmp_lt) begin
          ram_wdata_o = ram_rdata_i;
          idx_d       = par;
          state_d     = dmh_pkg::ST_UP_RD;
        end else begin
          state_d = dmh_pkg::ST_IDLE;
        end
      end

      // Release the held job and start the next pop when the root is due
      dmh_pkg::ST_CHECK: begin
        cmp_a = now_q;
        cmp_b = root_dl_q;
        if (have_q) begin
          emit_o.valid              = 1'b1;
          emit_o.res.kind           = dmh_pkg::KIND_EXPIRE;
          emit_o.res.job_handle_out = pop_h_q;
          emit_o.res.pending        = dmh_pkg::PEND_W'(cnt_q);
          emit_o.res.last           = !due;
          have_d                    = 1'b0;
        end
        if (due) begin
          pop_h_d = root_h_q;
          have_d  = 1'b1;
          cnt_d   = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = dmh_pkg::ST_CHECK;
          end else begin
            ram_raddr_o = IDX_W'(cnt_q - CNT_W'(1));
            state_d     = dmh_pkg::ST_POP_LAST;
          end
        end else begin
          state_d = dmh_pkg::ST_IDLE;
        end
      end

      // Take the last entry as the job to sift down from the root
      dmh_pkg::ST_POP_LAST: begin
        x_d        = ram_rdata_i;
        idx_d      = '0;
        best_sel_d = 1'b0;
        state_d    = dmh_pkg::ST_DN_L;
      end

      // Move the chosen child up, then fetch the left child or settle
      dmh_pkg::ST_DN_L: begin
        if (best_sel_q) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = best_q;
          idx_d       = best_idx_q;
          best_sel_d  = 1'b0;
          state_d     = dmh_pkg::ST_DN_L;
        end else if (l_w < cnt_w) begin
          ram_raddr_o = l_w[IDX_W-1:0];
          state_d     = dmh_pkg::ST_DN_LW;
        end else begin
          ram_we_o = 1'b1;
          state_d  = dmh_pkg::ST_CHECK;
        end
      end

      // Compare the left child against the sifted job
      dmh_pkg::ST_DN_LW: begin
        cmp_a = ram_rdata_i[ENT_W-1 -: TIME_BITS];
        cmp_b = x_q[ENT_W-1 -: TIME_BITS];
        if (cmp_lt) begin
          best_d     = ram_rdata_i;
          best_idx_d = l_w[IDX_W-1:0];
          best_sel_d = 1'b1;
        end else begin
          best_d     = x_q;
          best_sel_d = 1'b0;
        end
        if (r_w < cnt_w) begin
          ram_raddr_o = r_w[IDX_W-1:0];
          state_d     = dmh_pkg::ST_DN_RW;
        end else if (cmp_lt) begin
          state_d = dmh_pkg::ST_DN_L;
        end else begin
          ram_we_o = 1'b1;
          state_d  = dmh_pkg::ST_CHECK;
        end
      end

      // Compare the right child against the best so far
      dmh_pkg::ST_DN_RW: begin
        cmp_a = ram_rdata_i[ENT_W-1 -: TIME_BITS];
        cmp_b = best_q[ENT_W-1 -: TIME_BITS];
        if (cmp_lt) begin
          best_d     = ram_rdata_i;
          best_idx_d = r_w[IDX_W-1:0];
          best_sel_d = 1'b1;
          state_d    = dmh_pkg::ST_DN_L;
        end else if (best_sel_q) begin
          state_d = dmh_pkg::ST_DN_L;
        end else begin
          ram_we_o = 1'b1;
          state_d  = dmh_pkg::ST_CHECK;
        end
      end

      default: begin
        state_d = dmh_pkg::ST_IDLE;
      end
    endcase

    // Track the root entry on every write to the top of the heap
    if (ram_we_o && (ram_waddr_o == '0)) begin
      root_dl_d = ram_wdata_o[ENT_W-1 -: TIME_BITS];
      root_h_d  = ram_wdata_o[HW-1:0];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_wr_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (CNT_W'(ram_waddr_o) < cnt_q))
    else $error("heap write outside the occupied entries");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmh_pkg::ST_IDLE) |-> !have_q)
    else $error("released job left undelivered");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1)))
    || (cnt_q == CNT_W'($past(cnt_q) - CNT_W'(1))))
    else $error("heap count jumped by more than one");

endmodule

/* sv/deadline_min_heap_timer_queue_unit.sv */
// ----------------------------------------------------------------------------
// deadline_min_heap_timer_queue_unit
// Delayed-job timer queue on a binary min-heap keyed by deadline.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start; the word is taken on a clock edge with
// start high and busy low. A schedule word (mode 0) with zero delay is
// dispatched at once; otherwise the job is pushed with deadline now + delay,
// or rejected when the heap is full. A tick word (mode 1) advances the
// millisecond counter and releases every job whose deadline is at or before
// the new time, one result per job, the last one flagged.
// Each result sits on res_o for one cycle with done_o high; the receiver
// cannot hold results off, and every result must be taken when shown.
// Timing: a schedule result appears the cycle after the word is taken. A
// push then keeps busy high while it reads and compares each parent and
// writes the job into place. A tick keeps busy high while it checks the
// root and, for each released job, sifts the last entry down from the root.
// All walk steps go through the single heap RAM read port and one shared
// comparator.
// Reset: time and heap count clear at once; heap RAM needs no clearing.
// ----------------------------------------------------------------------------
module deadline_min_heap_timer_queue_unit #(
  parameter int unsigned HEAP_DEPTH = dmh_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned TIME_BITS  = dmh_pkg::TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dmh_pkg::dmh_req_t req_i,
  output logic              done_o,
  output dmh_pkg::dmh_res_t res_o
);

  localparam int unsigned IDX_W = $clog2(HEAP_DEPTH);
  localparam int unsigned ENT_W = TIME_BITS + dmh_pkg::HANDLE_W;

  dmh_pkg::dmh_emit_t emit;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;
  logic               done_q;
  dmh_pkg::dmh_res_t  res_q;

  dmh_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .emit_o      (emit),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  dmh_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Register each result word for one cycle on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      res_q <= emit.res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* bench/dmh_timer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dmh_timer_checker
// Watches the command and result channels of the timer queue, keeps its own
// copy of the clock and the deadline heap, predicts every result word and
// compares each one as it appears.
// ----------------------------------------------------------------------------
module dmh_timer_checker #(
  parameter int unsigned HEAP_DEPTH = dmh_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned TIME_BITS  = dmh_pkg::TIME_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  dmh_pkg::dmh_req_t req_i,
  input  logic              done_o,
  input  dmh_pkg::dmh_res_t res_o,
  output int                fail_count_o,
  output int                waiting_o,
  output int                words_o,
  output int                results_o,
  output int                rejects_o,
  output int                expiries_o
);

  localparam int MAX_REPORTS = 10;

  // Shadow timer state
  logic [TIME_BITS-1:0]         clock_ms;
  logic [TIME_BITS-1:0]         slot_due [HEAP_DEPTH];
  logic [dmh_pkg::HANDLE_W-1:0] slot_job [HEAP_DEPTH];
  int unsigned                  held_count;

  // Result words still owed by the block, oldest first
  dmh_pkg::dmh_res_t awaited_results [$];

  // Exchange two heap slots
  task automatic swap_slots(input int unsigned a, input int unsigned b);
    logic [TIME_BITS-1:0]         d;
    logic [dmh_pkg::HANDLE_W-1:0] j;
    d = slot_due[a];
    j = slot_job[a];
    slot_due[a] = slot_due[b];
    slot_job[a] = slot_job[b];
    slot_due[b] = d;
    slot_job[b] = j;
  endtask

  // Append a job at the bottom and climb while the parent is later
  task automatic heap_insert(input logic [TIME_BITS-1:0] due,
                             input logic [dmh_pkg::HANDLE_W-1:0] job);
    int unsigned i;
    int unsigned p;
    logic        climbing;
    i = held_count;
    held_count++;
    slot_due[i] = due;
    slot_job[i] = job;
    climbing = 1'b1;
    while (climbing && i > 0) begin
      p = (i - 1) / 2;
      if (slot_due[p] <= slot_due[i]) begin
        climbing = 1'b0;
      end else begin
        swap_slots(p, i);
        i = p;
      end
    end
  endtask

  // Remove the root, move the last slot up and sink it; ties go to the parent
  task automatic heap_take_min(output logic [dmh_pkg::HANDLE_W-1:0] job);
    int unsigned i;
    int unsigned l;
    int unsigned r;
    int unsigned s;
    logic        sinking;
    job = slot_job[0];
    i = 0;
    held_count--;
    slot_due[0] = slot_due[held_count];
    slot_job[0] = slot_job[held_count];
    sinking = 1'b1;
    while (sinking) begin
      l = 2 * i + 1;
      r = l + 1;
      s = i;
      if (l < held_count && slot_due[l] < slot_due[s]) s = l;
      if (r < held_count && slot_due[r] < slot_due[s]) s = r;
      if (s == i) begin
        sinking = 1'b0;
      end else begin
        swap_slots(i, s);
        i = s;
      end
    end
  endtask

  // Work out every result word that one accepted command word causes
  task automatic predict_results(input dmh_pkg::dmh_req_t w);
    dmh_pkg::dmh_res_t            r;
    logic [TIME_BITS-1:0]         due;
    logic [dmh_pkg::HANDLE_W-1:0] job;
    if (w.mode == dmh_pkg::MODE_SCHED) begin
      r.job_handle_out = w.job_handle;
      r.last = 1'b1;
      if (w.delay == '0) begin
        r.kind = dmh_pkg::KIND_DISPATCH;
      end else if (held_count >= HEAP_DEPTH) begin
        r.kind = dmh_pkg::KIND_REJECT;
      end else begin
        due = clock_ms + TIME_BITS'(w.delay);
        heap_insert(due, w.job_handle);
        r.kind = dmh_pkg::KIND_QUEUED;
      end
      r.pending = held_count[dmh_pkg::PEND_W-1:0];
      awaited_results.push_back(r);
    end else begin
      // Advance the clock, then release everything due in heap order
      clock_ms = clock_ms + TIME_BITS'(1);
      while (held_count > 0 && slot_due[0] <= clock_ms) begin
        heap_take_min(job);
        r.kind = dmh_pkg::KIND_EXPIRE;
        r.job_handle_out = job;
        r.pending = held_count[dmh_pkg::PEND_W-1:0];
        r.last = !(held_count > 0 && slot_due[0] <= clock_ms);
        awaited_results.push_back(r);
      end
    end
  endtask

  // Compare result words, then take in the command word of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    dmh_pkg::dmh_res_t want;
    if (!rst_ni) begin
      clock_ms = '0;
      held_count = 0;
      awaited_results.delete();
      fail_count_o = 0;
      words_o      = 0;
      results_o    = 0;
      rejects_o    = 0;
      expiries_o   = 0;
    end else begin
      if (done_o) begin
        results_o++;
        if (res_o.kind == dmh_pkg::KIND_REJECT) rejects_o++;
        if (res_o.kind == dmh_pkg::KIND_EXPIRE) expiries_o++;
        if (awaited_results.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("unexpected result word: kind %0d handle %h pending %0d last %0b",
                     res_o.kind, res_o.job_handle_out, res_o.pending, res_o.last);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (res_o.kind !== want.kind || res_o.job_handle_out !== want.job_handle_out ||
              res_o.pending !== want.pending || res_o.last !== want.last) begin
            if (fail_count_o < MAX_REPORTS)
              $display({"result %0d mismatch: kind %0d/%0d handle %h/%h ",
                        "pending %0d/%0d last %0b/%0b (expected/actual)"},
                       results_o, want.kind, res_o.kind, want.job_handle_out,
                       res_o.job_handle_out, want.pending, res_o.pending,
                       want.last, res_o.last);
            fail_count_o++;
          end
        end
      end
      if (start && !busy) begin
        words_o++;
        predict_results(req_i);
      end
    end
    waiting_o = awaited_results.size();
  end

endmodule

/* bench/deadline_min_heap_timer_queue_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_min_heap_timer_queue_unit_test
// Drives schedule and tick words into the timer queue in bursts with random
// gaps: directed corner words first, then random floods, tie groups, mixes
// and tick runs. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module deadline_min_heap_timer_queue_unit_test;

  localparam int WORD_TARGET  = 480;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 60;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start  = 1'b0;
  logic              busy;
  dmh_pkg::dmh_req_t req_i  = '0;
  logic              done_o;
  dmh_pkg::dmh_res_t res_o;

  int fail_count;
  int pending_count;
  int words_seen;
  int results_seen;
  int rejects_seen;
  int expiries_seen;

  int words_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;

  deadline_min_heap_timer_queue_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  dmh_timer_checker #(
    .HEAP_DEPTH (dmh_pkg::HEAP_DEPTH_DEF),
    .TIME_BITS  (dmh_pkg::TIME_BITS_DEF)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .done_o       (done_o),
    .res_o        (res_o),
    .fail_count_o (fail_count),
    .waiting_o    (pending_count),
    .words_o      (words_seen),
    .results_o    (results_seen),
    .rejects_o    (rejects_seen),
    .expiries_o   (expiries_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it; gap between bursts
  task automatic send_word(input dmh_pkg::mode_e mode, input logic [31:0] handle,
                           input logic [31:0] delay);
    dmh_pkg::dmh_req_t w;
    w.mode = mode;
    w.job_handle = handle;
    w.delay = delay;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
    burst_left--;
    req_i <= w;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic schedule_job(input logic [31:0] handle, input logic [31:0] delay);
    send_word(dmh_pkg::MODE_SCHED, handle, delay);
  endtask

  // Tick fields are ignored by the block: fill them with noise
  task automatic tick_once();
    send_word(dmh_pkg::MODE_TICK, $urandom, $urandom);
  endtask

  initial begin
    int n;
    int d;
    int r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty tick, immediate dispatch, extreme handles and delays, ties
    send_word(dmh_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    schedule_job(32'h0000_0000, 32'h0000_0000);
    schedule_job(32'hFFFF_FFFF, 32'h0000_0000);
    schedule_job(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    schedule_job(32'h0000_0000, 32'h0000_0001);
    schedule_job(32'hA5A5_0001, 32'h0000_0001);
    schedule_job(32'hA5A5_0002, 32'h0000_0001);
    schedule_job(32'hA5A5_0003, 32'h0000_0001);
    tick_once();
    send_word(dmh_pkg::MODE_TICK, 32'h0000_0000, 32'h0000_0000);
    schedule_job(32'h5A5A_0010, 32'h0000_0003);
    schedule_job(32'h5A5A_0011, 32'h0000_0002);
    schedule_job(32'h5A5A_0012, 32'h0000_0002);
    schedule_job(32'h5A5A_0013, 32'h0000_0005);
    schedule_job(32'h5555_AAAA, 32'h0000_0004);
    repeat (5) tick_once();

    // Random: floods that fill the heap, tie groups, mixes and tick runs
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(20, 40);
          d = $urandom_range(20, 50);
          r = $urandom_range(0, 2);
          repeat (n) begin
            if ($urandom_range(0, 15) == 0) schedule_job($urandom, 0);
            else if (r == 0) schedule_job($urandom, d);
            else schedule_job($urandom, $urandom_range(20, 50));
          end
        end
        2, 3: begin
          n = $urandom_range(3, 10);
          d = $urandom_range(1, 6);
          repeat (n) schedule_job($urandom, d);
          repeat (d + $urandom_range(0, 2)) tick_once();
        end
        4, 5, 6: begin
          repeat ($urandom_range(10, 30)) begin
            r = $urandom_range(0, 9);
            if (r < 4) tick_once();
            else if (r == 4) schedule_job($urandom, 0);
            else schedule_job($urandom, $urandom_range(1, 12));
          end
        end
        default: begin
          repeat ($urandom_range(5, 50)) tick_once();
        end
      endcase
    end
    start <= 1'b0;

    // Drain: wait for owed results, then let trailing work settle
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d command words and %0d result words", words_seen, results_seen);
    $display("  %0d rejected on a full heap, %0d released on expiry",
             rejects_seen, expiries_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/dmh_pkg.sv
sv/dmh_ram.sv
sv/dmh_ctrl.sv
sv/deadline_min_heap_timer_queue_unit.sv
bench/dmh_timer_checker.sv
bench/deadline_min_heap_timer_queue_unit_test.sv
